// ===== rtl/core/clamped_force_position_update_unit_macros.svh =====
// assertion macros shared by the force update unit
// expects clk and rst_n in the scope of each use
`ifndef CLAMPED_FORCE_POSITION_UPDATE_UNIT_MACROS_SVH
`define CLAMPED_FORCE_POSITION_UPDATE_UNIT_MACROS_SVH

// same-cycle implication
`define CFPU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFPU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cfpu_pkg.sv =====
// types and constants for the clamped force position update unit
// no dependencies
package cfpu_pkg;

  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 31;

  localparam logic [1:0] REG_STEP_WEIGHT = 2'd0;
  localparam logic [1:0] REG_MAX_FORCE   = 2'd1;
  localparam logic [1:0] REG_CLAMP_EN    = 2'd2;

  localparam logic [31:0] STEP_WEIGHT_RST = 32'h0001_0000;
  localparam logic [30:0] MAX_FORCE_RST   = 31'h0001_0000;
  localparam logic        CLAMP_EN_RST    = 1'b1;

  // side data carried past the square root
  typedef struct packed {
    logic [2:0][62:0] dvd;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic             last;
  } side_sqrt_t;

  // side data carried past the divider
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic             last;
    logic             clamp;
    logic             nz;
  } side_div_t;

endpackage

// ===== rtl/core/cfpu_delay.sv =====
// enabled shift register that keeps side data aligned with a pipelined unit
// depends on cfpu_pkg for default depth
module cfpu_delay #(
  parameter int W     = 1,
  parameter int DEPTH = cfpu_pkg::SQRT_STAGES
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] dl_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        dl_r[i] <= dl_r[i-1];
      end
    end
  end

  assign q = dl_r[DEPTH-1];

endmodule

// ===== rtl/core/cfpu_sqrt.sv =====
// pipelined floor square root of a 64-bit value, one result bit per stage
// depends on cfpu_pkg and the assertion macro header
`include "clamped_force_position_update_unit_macros.svh"

module cfpu_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [63:0] in_n,
  output logic        out_vld,
  output logic [31:0] out_root
);

  localparam int N = cfpu_pkg::SQRT_STAGES;

  logic [63:0] n_s   [N+1];
  logic [63:0] rt_s  [N+1];
  logic        vld_s [N+1];

  assign n_s[0]   = in_n;
  assign rt_s[0]  = '0;
  assign vld_s[0] = in_vld;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic [63:0] n_nxt, rt_nxt, n_r, rt_r;
    logic        vld_r;

    assign trial = rt_s[k] + BIT;

    always_comb begin
      if (n_s[k] >= trial) begin
        n_nxt  = n_s[k] - trial;
        rt_nxt = (rt_s[k] >> 1) + BIT;
      end else begin
        n_nxt  = n_s[k];
        rt_nxt = rt_s[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r  <= n_nxt;
        rt_r <= rt_nxt;
      end
    end

    assign n_s[k+1]   = n_r;
    assign rt_s[k+1]  = rt_r;
    assign vld_s[k+1] = vld_r;
  end

  assign out_vld  = vld_s[N];
  assign out_root = rt_s[N][31:0];

  // leftover of a floor root never exceeds twice the root
  `CFPU_ASSERT_IMP(a_sqrt_rem, out_vld, n_s[N] <= {rt_s[N][62:0], 1'b0}, "sqrt remainder too big")
  `CFPU_ASSERT_NXT(a_sqrt_vld, en && vld_s[N-1], out_vld, "sqrt valid lost in last stage")

endmodule

// ===== rtl/core/cfpu_div.sv =====
// pipelined restoring divider for three dividends over one shared divisor
// quotient bits 30 down to 0, one per stage; depends on cfpu_pkg
module cfpu_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [31:0]      divisor,
  input  logic [2:0][62:0] dvd,
  output logic             out_vld,
  output logic [2:0][30:0] quo
);

  localparam int N = cfpu_pkg::DIV_STAGES;

  logic [2:0][62:0] rem_s [N+1];
  logic [2:0][30:0] q_s   [N+1];
  logic [31:0]      dsr_s [N+1];
  logic             vld_s [N+1];

  assign rem_s[0] = dvd;
  assign q_s[0]   = '0;
  assign dsr_s[0] = divisor;
  assign vld_s[0] = in_vld;

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int B = N - 1 - s;
    logic [62:0]      trial;
    logic [2:0][62:0] rem_nxt, rem_r;
    logic [2:0][30:0] q_nxt, q_r;
    logic [31:0]      dsr_r;
    logic             vld_r;

    assign trial = {31'b0, dsr_s[s]} << B;

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        q_nxt[c] = q_s[s][c];
        if (rem_s[s][c] >= trial) begin
          rem_nxt[c]  = rem_s[s][c] - trial;
          q_nxt[c][B] = 1'b1;
        end else begin
          rem_nxt[c] = rem_s[s][c];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_s[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        dsr_r <= dsr_s[s];
      end
    end

    assign rem_s[s+1] = rem_r;
    assign q_s[s+1]   = q_r;
    assign dsr_s[s+1] = dsr_r;
    assign vld_s[s+1] = vld_r;
  end

  assign out_vld = vld_s[N];
  assign quo     = q_s[N];

endmodule

// ===== rtl/core/cfpu_move.sv =====
// final force selection, displacement multiply and saturating position add
// two register stages; depends on cfpu_pkg
module cfpu_move (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  cfpu_pkg::side_div_t   side,
  input  logic [2:0][30:0]      quo,
  input  logic [31:0]           step_weight,
  output logic                  out_vld,
  output logic [2:0][31:0]      new_pos,
  output logic [2:0][31:0]      frc,
  output logic                  moved,
  output logic                  last
);

  logic [2:0][31:0] fm;
  logic [2:0][31:0] fo_nxt;
  logic [2:0][62:0] prod_nxt;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      fm[c]       = side.clamp ? {1'b0, quo[c]} : side.mag[c];
      fo_nxt[c]   = side.neg[c] ? 32'd0 - fm[c] : fm[c];
      prod_nxt[c] = 63'({32'd0, fm[c]} * {32'd0, step_weight});
    end
  end

  logic             a_vld_r;
  logic [2:0][62:0] a_prod_r;
  logic [2:0][31:0] a_pos_r, a_fo_r;
  logic [2:0]       a_neg_r;
  logic             a_nz_r, a_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_prod_r <= prod_nxt;
      a_pos_r  <= side.pos;
      a_fo_r   <= fo_nxt;
      a_neg_r  <= side.neg;
      a_nz_r   <= side.nz;
      a_last_r <= side.last;
    end
  end

  logic [2:0][31:0] np_nxt;
  logic signed [48:0] ps, dd, sum;

  always_comb begin
    ps  = '0;
    dd  = '0;
    sum = '0;
    for (int c = 0; c < 3; c++) begin
      ps  = {{17{a_pos_r[c][31]}}, a_pos_r[c]};
      dd  = {2'b0, a_prod_r[c][62:16]};
      sum = a_neg_r[c] ? ps - dd : ps + dd;
      if (sum > 49'sh0_7FFF_FFFF) begin
        np_nxt[c] = 32'h7FFF_FFFF;
      end else if (sum < -49'sh0_8000_0000) begin
        np_nxt[c] = 32'h8000_0000;
      end else begin
        np_nxt[c] = sum[31:0];
      end
    end
  end

  logic             b_vld_r;
  logic [2:0][31:0] b_pos_r, b_fo_r;
  logic             b_moved_r, b_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_pos_r   <= np_nxt;
      b_fo_r    <= a_fo_r;
      b_moved_r <= a_nz_r;
      b_last_r  <= a_last_r;
    end
  end

  assign out_vld = b_vld_r;
  assign new_pos = b_pos_r;
  assign frc     = b_fo_r;
  assign moved   = b_moved_r;
  assign last    = b_last_r;

endmodule

// ===== rtl/core/clamped_force_position_update_unit.sv =====
// Steepest-descent position update with force length clamp, one atom per item.
// Fully pipelined: a new atom is taken every cycle unless the pipeline holds; it
// passes the 32-stage square root and the 31-stage clamp divider. When the result
// is not taken the whole pipeline holds. The user must write registers only while
// no item is in flight; the block itself does not enforce this.
// depends on cfpu_pkg, cfpu_delay, cfpu_sqrt, cfpu_div, cfpu_move and the macro header
`include "clamped_force_position_update_unit_macros.svh"

module clamped_force_position_update_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, pos_z, force_x, force_y, force_z
  input  logic [191:0] in_tdata,
  // restrained
  input  logic         in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_x, new_y, new_z, out_force_x, out_force_y, out_force_z
  output logic [191:0] out_tdata,
  // moved
  output logic         out_tuser,
  output logic         out_tlast
);

  logic [31:0] step_weight_r;
  logic [30:0] max_force_r;
  logic        clamp_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_weight_r <= cfpu_pkg::STEP_WEIGHT_RST;
      max_force_r   <= cfpu_pkg::MAX_FORCE_RST;
      clamp_en_r    <= cfpu_pkg::CLAMP_EN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cfpu_pkg::REG_STEP_WEIGHT: step_weight_r <= cfg_wdata;
        cfpu_pkg::REG_MAX_FORCE:   max_force_r   <= cfg_wdata[30:0];
        cfpu_pkg::REG_CLAMP_EN:    clamp_en_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // stage 1: magnitudes; a restrained atom enters with zero force
  logic [2:0][31:0] mag_nxt;
  logic [2:0]       neg_nxt;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [31:0] f;
      f          = in_tdata[96 + 32*c +: 32];
      neg_nxt[c] = f[31] && !in_tuser;
      mag_nxt[c] = in_tuser ? 32'd0 : (f[31] ? 32'd0 - f : f);
    end
  end

  logic             v1_r, v2_r, v3_r;
  logic [2:0][31:0] pos1_r, mag1_r, pos2_r, mag2_r, pos3_r, mag3_r;
  logic [2:0]       neg1_r, neg2_r, neg3_r;
  logic             last1_r, last2_r, last3_r;
  logic [2:0][62:0] sq2_r, dvd2_r, dvd3_r;
  logic [63:0]      sum3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos1_r  <= in_tdata[95:0];
      mag1_r  <= mag_nxt;
      neg1_r  <= neg_nxt;
      last1_r <= in_tlast;
      // stage 2: squares and clamp dividends
      for (int c = 0; c < 3; c++) begin
        sq2_r[c]  <= 63'({32'd0, mag1_r[c]} * {32'd0, mag1_r[c]});
        dvd2_r[c] <= 63'({32'd0, mag1_r[c]} * {33'd0, max_force_r});
      end
      pos2_r  <= pos1_r;
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
      last2_r <= last1_r;
      // stage 3: squared length
      sum3_r  <= {1'b0, sq2_r[0]} + {1'b0, sq2_r[1]} + {1'b0, sq2_r[2]};
      dvd3_r  <= dvd2_r;
      pos3_r  <= pos2_r;
      mag3_r  <= mag2_r;
      neg3_r  <= neg2_r;
      last3_r <= last2_r;
    end
  end

  cfpu_pkg::side_sqrt_t ss_in, ss_out;
  assign ss_in.dvd  = dvd3_r;
  assign ss_in.pos  = pos3_r;
  assign ss_in.mag  = mag3_r;
  assign ss_in.neg  = neg3_r;
  assign ss_in.last = last3_r;

  logic        sq_vld;
  logic [31:0] len;

  cfpu_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (v3_r),
    .in_n     (sum3_r),
    .out_vld  (sq_vld),
    .out_root (len)
  );

  cfpu_delay #(
    .W     ($bits(cfpu_pkg::side_sqrt_t)),
    .DEPTH (cfpu_pkg::SQRT_STAGES)
  ) u_dly_sqrt (
    .clk (clk),
    .en  (adv),
    .d   (ss_in),
    .q   (ss_out)
  );

  cfpu_pkg::side_div_t sd_in, sd_out;
  assign sd_in.pos   = ss_out.pos;
  assign sd_in.mag   = ss_out.mag;
  assign sd_in.neg   = ss_out.neg;
  assign sd_in.last  = ss_out.last;
  assign sd_in.clamp = clamp_en_r && (len > {1'b0, max_force_r});
  assign sd_in.nz    = (len != 32'd0);

  logic             dv_vld;
  logic [2:0][30:0] quo;

  cfpu_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (sq_vld),
    .divisor (len),
    .dvd     (ss_out.dvd),
    .out_vld (dv_vld),
    .quo     (quo)
  );

  cfpu_delay #(
    .W     ($bits(cfpu_pkg::side_div_t)),
    .DEPTH (cfpu_pkg::DIV_STAGES)
  ) u_dly_div (
    .clk (clk),
    .en  (adv),
    .d   (sd_in),
    .q   (sd_out)
  );

  logic [2:0][31:0] new_pos, frc;

  cfpu_move u_move (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .in_vld      (dv_vld),
    .side        (sd_out),
    .quo         (quo),
    .step_weight (step_weight_r),
    .out_vld     (out_tvalid),
    .new_pos     (new_pos),
    .frc         (frc),
    .moved       (out_tuser),
    .last        (out_tlast)
  );

  assign out_tdata = {frc, new_pos};

  logic frc_zero, quo_in_lim;
  assign frc_zero   = (out_tdata[191:96] == 96'd0);
  assign quo_in_lim = (quo[0] <= max_force_r) && (quo[1] <= max_force_r) &&
                      (quo[2] <= max_force_r);

  // an atom that did not move leaves with zero force
  `CFPU_ASSERT_IMP(a_still_no_force, out_tvalid && !out_tuser, frc_zero, "unmoved atom has force")
  // a clamped component never exceeds the limit
  `CFPU_ASSERT_IMP(a_clamp_limit, dv_vld && sd_out.clamp, quo_in_lim, "clamped force over limit")

endmodule
